// File: sv/circle_point_generator_unit_defines.svh
// Assertion macros for the circle point generator checker.
// Used by the checker file only; no other dependencies.
`ifndef CIRCLE_POINT_GENERATOR_UNIT_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_UNIT_DEFINES_SVH

// Check that antecedent a implies consequent b on the next clock.
`define CPG_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("cpg check failed");

// Check that antecedent a implies consequent b in the same clock.
`define CPG_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("cpg check failed");

`endif

// File: sv/cpg_pkg.sv
// Shared constants, types and functions of the circle point generator.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

    localparam int INDEX_WIDTH    = 16;
    localparam int CORDIC_STEPS   = 24;
    localparam int COUNT_WIDTH    = 16;
    localparam int RADIUS_WIDTH   = 31;
    localparam int DATA_WIDTH     = 32;
    localparam int PHASE_WIDTH    = 32;
    localparam int GAIN_WIDTH     = 32;
    localparam int PROD_WIDTH     = RADIUS_WIDTH + GAIN_WIDTH + 1;
    localparam int X0_WIDTH       = RADIUS_WIDTH + GAIN_WIDTH - 16;
    localparam int CORDIC_WIDTH   = X0_WIDTH + 3;
    localparam int ANGLE_WIDTH    = 34;
    localparam int STEP_WIDTH     = $clog2(CORDIC_STEPS);
    localparam int MUL_CNT_WIDTH  = $clog2(GAIN_WIDTH);
    localparam int CMP_WIDTH      =
        ((INDEX_WIDTH > COUNT_WIDTH) ? INDEX_WIDTH : COUNT_WIDTH) + 1;

    localparam logic [GAIN_WIDTH-1:0] GAIN_Q32 = 32'h9B74EDA8;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_RADIUS      = 2'd0;
    localparam t_cfg_index CFG_POINT_COUNT = 2'd1;
    localparam t_cfg_index CFG_HEIGHT      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULDIV,
        ST_ROTATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                    done;
        logic [PHASE_WIDTH-1:0]  phase;
        logic [X0_WIDTH-1:0]     x0;
    } t_dm_result;

    // arctan(2^-i) as a fraction of a turn, Q0.32
    function automatic logic [PHASE_WIDTH-1:0] atan_turn(input logic [STEP_WIDTH-1:0] step);
        logic [PHASE_WIDTH-1:0] v;
        v = '0;
        unique case (5'(step))
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round to nearest (ties up), drop 16 guard bits, saturate to 32 bits
    function automatic logic [DATA_WIDTH-1:0] round_sat(
        input logic signed [CORDIC_WIDTH-1:0] v
    );
        logic signed [CORDIC_WIDTH-1:0] r;
        r = (v + CORDIC_WIDTH'(32768)) >>> 16;
        if (r > CORDIC_WIDTH'(64'sh7FFFFFFF)) begin
            return 32'h7FFFFFFF;
        end else if (r < -CORDIC_WIDTH'(64'sh80000000)) begin
            return 32'h80000000;
        end
        return r[DATA_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/circle_point_generator_unit.sv
// Top level of the circle point generator: registers, sequencer, output stage.
// Depends on cpg_pkg, cpg_divmul and cpg_cordic.
`timescale 1ns / 1ps
`default_nettype none

// Each transaction on the slave stream with step_request set produces one set
// point (x, y, z) on a horizontal circle and advances the point index, which
// wraps at point_count (a count of zero acts as one; an index left stale by a
// lowered count restarts at point 0). The angle is index/point_count of a
// turn; x = radius*cos, y = radius*sin, rounded to Q16.16 and saturated, z is
// the height register. A transaction with step_request clear is consumed and
// produces nothing. A point passes through the bit-serial phase divider,
// which also runs the serial radius-gain multiply, then the phase fold, the
// CORDIC launch and the CORDIC micro-rotations, then the finish state, which
// loads the rounded output register once it is free. One point is in
// flight at a time, so the next request is taken the cycle after the output
// register loads; a finished point waits in the output register while the
// next request is taken. Configuration writes are always accepted and must
// only be issued while no point is in flight.
module circle_point_generator_unit (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // config write channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [31:0]             i_cfg_data,
    // request stream
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [7:0]              s_axis_tdata,   // [0] step_request
    // set point stream
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [95:0]                  m_axis_tdata    // [31:0] pos_x, [63:32] pos_y,
                                                         // [95:64] pos_z
);

    cpg_pkg::t_state                            r_state, n_state;

    logic [cpg_pkg::RADIUS_WIDTH-1:0]           r_radius;
    logic [cpg_pkg::COUNT_WIDTH-1:0]            r_point_count;
    logic [cpg_pkg::DATA_WIDTH-1:0]             r_height;
    logic [cpg_pkg::INDEX_WIDTH-1:0]            r_index;
    logic [1:0]                                 r_quad;
    logic signed [cpg_pkg::ANGLE_WIDTH-1:0]     r_z0;
    logic                                       r_busy_cordic_q;

    logic                                       r_out_valid;
    logic [cpg_pkg::DATA_WIDTH-1:0]             r_pos_x;
    logic [cpg_pkg::DATA_WIDTH-1:0]             r_pos_y;
    logic [cpg_pkg::DATA_WIDTH-1:0]             r_pos_z;

    logic                                       w_accept;
    logic                                       w_request;
    logic [cpg_pkg::CMP_WIDTH-1:0]              w_count;
    logic [cpg_pkg::CMP_WIDTH-1:0]              w_idx;
    logic [cpg_pkg::CMP_WIDTH-1:0]              w_nxt;
    logic [cpg_pkg::CMP_WIDTH-1:0]              w_nxt_idx;
    logic                                       w_dm_start;
    logic                                       w_cordic_start;
    logic                                       w_load_out;
    cpg_pkg::t_dm_result                        w_dm;
    logic [cpg_pkg::PHASE_WIDTH-1:0]            w_biased;
    logic [1:0]                                 w_q;
    logic [cpg_pkg::PHASE_WIDTH-1:0]            w_d;
    logic signed [cpg_pkg::CORDIC_WIDTH-1:0]    w_cx, w_cy;
    logic                                       w_cdone;
    logic signed [cpg_pkg::CORDIC_WIDTH-1:0]    w_fx, w_fy;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == cpg_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_request     = w_accept && s_axis_tdata[0];

    // effective count and index of the point to produce
    assign w_count = (r_point_count == '0) ? cpg_pkg::CMP_WIDTH'(1)
                                            : cpg_pkg::CMP_WIDTH'(r_point_count);
    assign w_idx   = (cpg_pkg::CMP_WIDTH'(r_index) >= w_count) ? '0
                                                              : cpg_pkg::CMP_WIDTH'(r_index);
    assign w_nxt   = w_idx + 1'b1;
    // wrap at the count, and also where the index register would overflow
    assign w_nxt_idx = ((w_nxt >= w_count) || (w_nxt[cpg_pkg::CMP_WIDTH-1:cpg_pkg::INDEX_WIDTH] != '0))
                     ? '0 : w_nxt;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= cpg_pkg::RADIUS_WIDTH'(65536);
            r_point_count <= cpg_pkg::COUNT_WIDTH'(360);
            r_height      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cpg_pkg::CFG_RADIUS:      r_radius      <= i_cfg_data[cpg_pkg::RADIUS_WIDTH-1:0];
                cpg_pkg::CFG_POINT_COUNT: r_point_count <= i_cfg_data[cpg_pkg::COUNT_WIDTH-1:0];
                cpg_pkg::CFG_HEIGHT:      r_height      <= i_cfg_data;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    // advance the point index as soon as a request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else if (w_request) begin
            r_index <= w_nxt_idx[cpg_pkg::INDEX_WIDTH-1:0];
        end
    end

    assign w_dm_start = w_request;

    cpg_divmul u_divmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_dm_start),
        .i_index  (w_idx[cpg_pkg::COUNT_WIDTH-1:0]),
        .i_count  (w_count[cpg_pkg::COUNT_WIDTH-1:0]),
        .i_radius (r_radius),
        .o_result (w_dm)
    );

    // fold the phase into +-1/8 turn around the nearest quadrant
    assign w_biased = w_dm.phase + 32'h20000000;
    assign w_q      = w_biased[cpg_pkg::PHASE_WIDTH-1 -: 2];
    assign w_d      = w_dm.phase - {w_q, {(cpg_pkg::PHASE_WIDTH-2){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_dm.done) begin
            r_quad <= w_q;
            r_z0   <= signed'({{(cpg_pkg::ANGLE_WIDTH-cpg_pkg::PHASE_WIDTH)
                                {w_d[cpg_pkg::PHASE_WIDTH-1]}}, w_d});
        end
    end

    // CORDIC launches the cycle after the fold registers load
    assign w_cordic_start = (r_state == cpg_pkg::ST_ROTATE) && !r_busy_cordic_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_cordic_q <= 1'b0;
        end else begin
            r_busy_cordic_q <= (r_state == cpg_pkg::ST_ROTATE);
        end
    end

    cpg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_start),
        .i_x0    (w_dm.x0),
        .i_z0    (r_z0),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_done  (w_cdone)
    );

    // restore the quadrant by swapping and negating
    always_comb begin
        w_fx = w_cx;
        w_fy = w_cy;
        unique case (r_quad)
            2'd1: begin
                w_fx = -w_cy;
                w_fy = w_cx;
            end
            2'd2: begin
                w_fx = -w_cx;
                w_fy = -w_cy;
            end
            2'd3: begin
                w_fx = w_cy;
                w_fy = -w_cx;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_load_out = 1'b0;
        unique case (r_state)
            cpg_pkg::ST_IDLE: begin
                if (w_request) begin
                    n_state = cpg_pkg::ST_MULDIV;
                end
            end
            cpg_pkg::ST_MULDIV: begin
                if (w_dm.done) begin
                    n_state = cpg_pkg::ST_ROTATE;
                end
            end
            cpg_pkg::ST_ROTATE: begin
                if (w_cdone) begin
                    n_state = cpg_pkg::ST_FINISH;
                end
            end
            cpg_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = cpg_pkg::ST_IDLE;
                end
            end
            default: n_state = cpg_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_pos_x <= cpg_pkg::round_sat(w_fx);
            r_pos_y <= cpg_pkg::round_sat(w_fy);
            r_pos_z <= r_height;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_pos_z, r_pos_y, r_pos_x};

endmodule

`default_nettype wire

// File: sv/cpg_divmul.sv
// Bit-serial restoring divider (phase) and shift-add multiplier (CORDIC start).
// Depends on cpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpg_divmul (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [cpg_pkg::COUNT_WIDTH-1:0]     i_index,
    input  wire logic [cpg_pkg::COUNT_WIDTH-1:0]     i_count,
    input  wire logic [cpg_pkg::RADIUS_WIDTH-1:0]    i_radius,
    output cpg_pkg::t_dm_result                      o_result
);

    logic                                   r_busy;
    logic                                   r_done;
    logic [cpg_pkg::MUL_CNT_WIDTH-1:0]      r_cnt;
    logic [cpg_pkg::COUNT_WIDTH-1:0]        r_rem;
    logic [cpg_pkg::COUNT_WIDTH-1:0]        r_count;
    logic [cpg_pkg::PHASE_WIDTH-1:0]        r_quo;
    logic [cpg_pkg::PROD_WIDTH-1:0]         r_prod;

    logic [cpg_pkg::COUNT_WIDTH:0]          w_dbl;
    logic [cpg_pkg::COUNT_WIDTH:0]          w_sub;
    logic                                   w_ge;
    logic [cpg_pkg::GAIN_WIDTH:0]           w_add;

    assign w_dbl = {r_rem, 1'b0};
    assign w_ge  = (w_dbl >= {1'b0, r_count});
    assign w_sub = w_dbl - {1'b0, r_count};
    assign w_add = {1'b0, r_prod[cpg_pkg::PROD_WIDTH-1 -: cpg_pkg::GAIN_WIDTH]}
                 + (r_prod[0] ? {1'b0, cpg_pkg::GAIN_Q32} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {cpg_pkg::MUL_CNT_WIDTH{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_index;
            r_count <= i_count;
            r_quo   <= '0;
            r_prod  <= {{(cpg_pkg::PROD_WIDTH-cpg_pkg::RADIUS_WIDTH){1'b0}}, i_radius};
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[cpg_pkg::COUNT_WIDTH-1:0] : w_dbl[cpg_pkg::COUNT_WIDTH-1:0];
            r_quo  <= {r_quo[cpg_pkg::PHASE_WIDTH-2:0], w_ge};
            r_prod <= {w_add, r_prod[cpg_pkg::PROD_WIDTH-cpg_pkg::GAIN_WIDTH-1:1]};
        end
    end

    assign o_result.done  = r_done;
    assign o_result.phase = r_quo;
    assign o_result.x0    = r_prod[cpg_pkg::X0_WIDTH+15:16];

endmodule

`default_nettype wire

// File: sv/cpg_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per clock.
// Depends on cpg_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module cpg_cordic (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic [cpg_pkg::X0_WIDTH-1:0]            i_x0,
    input  wire logic signed [cpg_pkg::ANGLE_WIDTH-1:0]  i_z0,
    output logic signed [cpg_pkg::CORDIC_WIDTH-1:0]      o_x,
    output logic signed [cpg_pkg::CORDIC_WIDTH-1:0]      o_y,
    output logic                                         o_done
);

    logic                                       r_busy;
    logic                                       r_done;
    logic [cpg_pkg::STEP_WIDTH-1:0]             r_i;
    logic signed [cpg_pkg::CORDIC_WIDTH-1:0]    r_x;
    logic signed [cpg_pkg::CORDIC_WIDTH-1:0]    r_y;
    logic signed [cpg_pkg::ANGLE_WIDTH-1:0]     r_z;

    logic signed [cpg_pkg::CORDIC_WIDTH-1:0]    w_dx;
    logic signed [cpg_pkg::CORDIC_WIDTH-1:0]    w_dy;
    logic signed [cpg_pkg::ANGLE_WIDTH-1:0]     w_at;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = signed'({{(cpg_pkg::ANGLE_WIDTH-cpg_pkg::PHASE_WIDTH){1'b0}},
                           cpg_pkg::atan_turn(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == cpg_pkg::STEP_WIDTH'(cpg_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= signed'({{(cpg_pkg::CORDIC_WIDTH-cpg_pkg::X0_WIDTH){1'b0}}, i_x0});
            r_y <= '0;
            r_z <= i_z0;
        end else if (r_busy) begin
            // rotate toward zero residual angle
            if (!r_z[cpg_pkg::ANGLE_WIDTH-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: sv/cpg_checker.sv
// Port-level checks of the circle point generator, bound to the top level.
// Depends on circle_point_generator_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "circle_point_generator_unit_defines.svh"

module cpg_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    input  wire logic          s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,
    input  wire logic          m_axis_tvalid,
    input  wire logic          m_axis_tready
);

    // a held set point stays offered
    `CPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a real request makes the block busy on the next cycle
    `CPG_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tdata[0], !s_axis_tready)

    // a new set point appears only at the end of a busy period
    `CPG_ASSERT_NOW(a_out_after_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind circle_point_generator_unit cpg_checker u_cpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
